### rtl/core/scdg_pkg.sv
// Shared types, constants and glyph tables for the scalable digit glyph pixel block.
package scdg_pkg;

    // Field and geometry widths
    localparam int unsigned WID_W   = 8;   // glyph width register
    localparam int unsigned ROW_W   = 9;   // pixel row, also glyph height
    localparam int unsigned COL_W   = 8;   // pixel column
    localparam int unsigned DIGIT_W = 4;

    // Stroke thickness is width / BASE_DIVISOR; a power of two, so a shift
    localparam int unsigned BASE_DIVISOR = 8;
    localparam int unsigned DIV_SHIFT    = $clog2(BASE_DIVISOR);
    localparam int unsigned STROKE_W     = WID_W - DIV_SHIFT;

    // Largest legal glyph width; the 8-bit register cannot exceed it
    localparam int unsigned MAX_WIDTH = 255;

    localparam logic [WID_W-1:0] WIDTH_RESET = WID_W'(32);

    // Digits that have their own band layout
    localparam logic [DIGIT_W-1:0] DIGIT_ZERO  = 4'd0;
    localparam logic [DIGIT_W-1:0] DIGIT_ONE   = 4'd1;
    localparam logic [DIGIT_W-1:0] DIGIT_TWO   = 4'd2;
    localparam logic [DIGIT_W-1:0] DIGIT_THREE = 4'd3;
    localparam logic [DIGIT_W-1:0] DIGIT_FOUR  = 4'd4;
    localparam logic [DIGIT_W-1:0] DIGIT_FIVE  = 4'd5;
    localparam logic [DIGIT_W-1:0] DIGIT_SIX   = 4'd6;
    localparam logic [DIGIT_W-1:0] DIGIT_SEVEN = 4'd7;
    localparam logic [DIGIT_W-1:0] DIGIT_EIGHT = 4'd8;
    localparam logic [DIGIT_W-1:0] DIGIT_NINE  = 4'd9;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_THIN    = 2'd1,
        ST_OUTSIDE = 2'd2
    } t_status;

    typedef struct packed {
        logic [DIGIT_W-1:0] digit;
        logic [ROW_W-1:0]   pixel_row;
        logic [COL_W-1:0]   pixel_col;
    } t_in_beat;

    typedef struct packed {
        logic    pixel_on;
        t_status status;
    } t_out_beat;

    // First stage: item plus per-width geometry
    typedef struct packed {
        logic [DIGIT_W-1:0]  digit;
        logic [ROW_W-1:0]    row;
        logic [COL_W-1:0]    col;
        logic [WID_W-1:0]    wid;
        logic [STROKE_W-1:0] stroke;
        logic [ROW_W-1:0]    height;
        logic [ROW_W-2:0]    hi_four;   // split row offset, digit four
        logic [ROW_W-2:0]    hi_five;   // split row offset, five-band digits
        t_status             status;
    } t_geom;

    // Second stage: band and side-bar hits
    typedef struct packed {
        logic [DIGIT_W-1:0] digit;
        t_status            status;
        logic               left;
        logic               right;
        logic               top;        // row < R
        logic               above_bot;  // row < H - R
        logic               four_up;    // row < hi
        logic               four_bar;   // row < hi + R
        logic               five_up;    // row < R + hi
        logic               five_bar;   // row < 2R + hi
    } t_band;

    // Side bars per five-band digit: bit0 upper-left, bit1 upper-right,
    // bit2 lower-left, bit3 lower-right
    function automatic logic [3:0] zone_sides(input logic [DIGIT_W-1:0] d);
        logic [3:0] s;
        s = 4'h0;
        unique case (d)
            DIGIT_TWO:   s = 4'h6;
            DIGIT_THREE: s = 4'hA;
            DIGIT_FIVE:  s = 4'h9;
            DIGIT_SIX:   s = 4'hD;
            DIGIT_EIGHT: s = 4'hF;
            DIGIT_NINE:  s = 4'hB;
            default:     s = 4'h0;
        endcase
        return s;
    endfunction

endpackage

### rtl/core/scdg_geom.sv
// Stage one: stroke thickness, glyph height, split rows and range status.
module scdg_geom (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  scdg_pkg::t_in_beat            i_beat,
    input  logic [scdg_pkg::WID_W-1:0]    i_wid,
    output scdg_pkg::t_geom               o_geom
);

    logic [scdg_pkg::STROKE_W-1:0] stroke;
    logic [scdg_pkg::ROW_W-1:0]    height;
    logic [scdg_pkg::ROW_W-1:0]    three_r;
    logic [scdg_pkg::ROW_W-1:0]    s_four;
    logic [scdg_pkg::ROW_W-1:0]    s_five;
    logic [scdg_pkg::ROW_W-1:0]    hi_four;
    logic [scdg_pkg::ROW_W-1:0]    hi_five;
    scdg_pkg::t_geom               n_geom;
    scdg_pkg::t_geom               r_geom;

    // Thickness and height
    assign stroke  = i_wid[scdg_pkg::WID_W-1:scdg_pkg::DIV_SHIFT];
    assign height  = {i_wid, 1'b0};
    assign three_r = scdg_pkg::ROW_W'({stroke, 1'b0}) + scdg_pkg::ROW_W'(stroke);

    // Split rows: hi = S - S/2, crowded glyph takes S as zero
    assign s_four  = height - scdg_pkg::ROW_W'(stroke);
    assign s_five  = (height >= three_r) ? (height - three_r) : '0;
    assign hi_four = s_four - (s_four >> 1);
    assign hi_five = s_five - (s_five >> 1);

    always_comb begin
        n_geom         = '0;
        n_geom.digit   = i_beat.digit;
        n_geom.row     = i_beat.pixel_row;
        n_geom.col     = i_beat.pixel_col;
        n_geom.wid     = i_wid;
        n_geom.stroke  = stroke;
        n_geom.height  = height;
        n_geom.hi_four = hi_four[scdg_pkg::ROW_W-2:0];
        n_geom.hi_five = hi_five[scdg_pkg::ROW_W-2:0];
        // thin check wins over the range check
        if (stroke == '0) begin
            n_geom.status = scdg_pkg::ST_THIN;
        end else if ((i_beat.pixel_row >= height) || (i_beat.pixel_col >= i_wid)) begin
            n_geom.status = scdg_pkg::ST_OUTSIDE;
        end else begin
            n_geom.status = scdg_pkg::ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_geom <= n_geom;
        end
    end

    assign o_geom = r_geom;

endmodule

### rtl/core/scdg_band.sv
// Stage two: compares row and column against the bar and band edges.
module scdg_band (
    input  logic              i_clk,
    input  logic              i_en,
    input  scdg_pkg::t_geom   i_geom,
    output scdg_pkg::t_band   o_band
);

    logic [scdg_pkg::ROW_W-1:0] r_ext;
    logic [scdg_pkg::ROW_W-1:0] bot_edge;
    logic [scdg_pkg::ROW_W-1:0] four_edge;
    logic [scdg_pkg::ROW_W-1:0] five_up_edge;
    logic [scdg_pkg::ROW_W-1:0] five_bar_edge;
    logic [scdg_pkg::COL_W-1:0] right_edge;
    scdg_pkg::t_band            n_band;
    scdg_pkg::t_band            r_band;

    // Band edges
    assign r_ext         = scdg_pkg::ROW_W'(i_geom.stroke);
    assign bot_edge      = i_geom.height - r_ext;
    assign four_edge     = scdg_pkg::ROW_W'(i_geom.hi_four) + r_ext;
    assign five_up_edge  = scdg_pkg::ROW_W'(i_geom.hi_five) + r_ext;
    assign five_bar_edge = five_up_edge + r_ext;
    assign right_edge    = i_geom.wid - scdg_pkg::COL_W'(i_geom.stroke);

    always_comb begin
        n_band           = '0;
        n_band.digit     = i_geom.digit;
        n_band.status    = i_geom.status;
        n_band.left      = i_geom.col < scdg_pkg::COL_W'(i_geom.stroke);
        n_band.right     = i_geom.col >= right_edge;
        n_band.top       = i_geom.row < r_ext;
        n_band.above_bot = i_geom.row < bot_edge;
        n_band.four_up   = i_geom.row < scdg_pkg::ROW_W'(i_geom.hi_four);
        n_band.four_bar  = i_geom.row < four_edge;
        n_band.five_up   = i_geom.row < five_up_edge;
        n_band.five_bar  = i_geom.row < five_bar_edge;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_band <= n_band;
        end
    end

    assign o_band = r_band;

endmodule

### rtl/core/scdg_pick.sv
// Stage three: per-digit stroke selection into the output register.
module scdg_pick (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  scdg_pkg::t_band      i_band,
    output scdg_pkg::t_out_beat  o_beat
);

    logic [3:0]          sides;
    logic                upper;
    logic                lower;
    logic                hit;
    scdg_pkg::t_out_beat n_beat;
    scdg_pkg::t_out_beat r_beat;

    // Side bars shown in the upper and lower zones of five-band digits
    assign sides = scdg_pkg::zone_sides(i_band.digit);
    assign upper = (sides[0] && i_band.left) || (sides[1] && i_band.right);
    assign lower = (sides[2] && i_band.left) || (sides[3] && i_band.right);

    always_comb begin
        hit = 1'b0;
        unique case (i_band.digit)
            scdg_pkg::DIGIT_ZERO: begin
                hit = (i_band.top || !i_band.above_bot) ? 1'b1
                                                         : (i_band.left || i_band.right);
            end
            scdg_pkg::DIGIT_ONE: begin
                hit = i_band.right;
            end
            scdg_pkg::DIGIT_SEVEN: begin
                hit = i_band.top || i_band.right;
            end
            scdg_pkg::DIGIT_FOUR: begin
                if (i_band.four_up) begin
                    hit = i_band.left || i_band.right;
                end else if (i_band.four_bar) begin
                    hit = 1'b1;
                end else begin
                    hit = i_band.right;
                end
            end
            scdg_pkg::DIGIT_TWO, scdg_pkg::DIGIT_THREE, scdg_pkg::DIGIT_FIVE,
            scdg_pkg::DIGIT_SIX, scdg_pkg::DIGIT_EIGHT, scdg_pkg::DIGIT_NINE: begin
                // bands in order: top, upper, middle, lower, bottom
                if (i_band.top) begin
                    hit = 1'b1;
                end else if (i_band.five_up) begin
                    hit = upper;
                end else if (i_band.five_bar) begin
                    hit = 1'b1;
                end else if (i_band.above_bot) begin
                    hit = lower;
                end else begin
                    hit = 1'b1;
                end
            end
            // digits above nine are blank
            default: begin
                hit = 1'b0;
            end
        endcase
    end

    always_comb begin
        n_beat          = '0;
        n_beat.status   = i_band.status;
        n_beat.pixel_on = (i_band.status == scdg_pkg::ST_OK) && hit;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_beat <= n_beat;
        end
    end

    assign o_beat = r_beat;

endmodule

### rtl/core/scalable_digit_glyph_pixel.sv
// Top level of the scalable digit glyph pixel block: handshake, width register, pipeline.
//
// Usage:
//   Input channel (i_valid, i_beat, o_stall) carries one pixel request per beat:
//   digit, pixel_row, pixel_col. Output channel (o_valid, o_beat, i_stall)
//   returns pixel_on and status for each request, in order.
//   The glyph width register is written with i_cfg_we / i_cfg_wdata while the
//   block is idle; the glyph is that many pixels wide and twice as tall.
// Pipeline and throughput:
//   An accepted input beat reaches o_valid through three register stages
//   (geometry, band compares, digit select into the output register).
//   One beat per cycle sustained while the receiver does not stall.
// Reset:
//   i_rst_n (synchronous, active low) empties the pipeline and sets the glyph
//   width to 32.
// Stall:
//   i_stall holds the output beat; earlier stages keep filling until every
//   stage holds a beat, and only then is o_stall raised toward the sender.
module scalable_digit_glyph_pixel (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [scdg_pkg::WID_W-1:0]    i_cfg_wdata,
    input  logic                          i_valid,
    input  scdg_pkg::t_in_beat            i_beat,
    output logic                          o_stall,
    output logic                          o_valid,
    output scdg_pkg::t_out_beat           o_beat,
    input  logic                          i_stall
);

    logic [scdg_pkg::WID_W-1:0] r_glyph_width;
    logic                       r_v1;
    logic                       r_v2;
    logic                       r_v3;
    logic                       ready1;
    logic                       ready2;
    logic                       ready3;
    scdg_pkg::t_geom            geom;
    scdg_pkg::t_band            band;

    // Glyph width register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_glyph_width <= scdg_pkg::WIDTH_RESET;
        end else if (i_cfg_we) begin
            r_glyph_width <= i_cfg_wdata;
        end
    end

    // A stage loads when it is empty or its beat moves on
    assign ready3  = !r_v3 || !i_stall;
    assign ready2  = !r_v2 || ready3;
    assign ready1  = !r_v1 || ready2;
    assign o_stall = !ready1;
    assign o_valid = r_v3;

    // Valid bits travel with the stage registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (ready1) begin
                r_v1 <= i_valid;
            end
            if (ready2) begin
                r_v2 <= r_v1;
            end
            if (ready3) begin
                r_v3 <= r_v2;
            end
        end
    end

    scdg_geom u_geom (
        .i_clk  (i_clk),
        .i_en   (ready1),
        .i_beat (i_beat),
        .i_wid  (r_glyph_width),
        .o_geom (geom)
    );

    scdg_band u_band (
        .i_clk  (i_clk),
        .i_en   (ready2),
        .i_geom (geom),
        .o_band (band)
    );

    scdg_pick u_pick (
        .i_clk  (i_clk),
        .i_en   (ready3),
        .i_band (band),
        .o_beat (o_beat)
    );

`ifndef NO_ASSERTIONS
    // Upstream sees stall only with every stage occupied
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_v1 && r_v2 && r_v3))
        else $error("input stalled with a free pipeline stage");

    // A beat never waits in front of an empty stage
    a_no_bubble: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && !r_v2) |=> r_v2)
        else $error("stage one beat did not advance into empty stage two");

    // Output valid drops only after the last beat was taken
    a_drop_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_valid) |-> $past(!i_stall))
        else $error("output beat dropped while stalled");

    // Error status always comes with background
    a_err_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_beat.status != scdg_pkg::ST_OK)) |-> !o_beat.pixel_on)
        else $error("foreground pixel reported with error status");
`endif

endmodule

### tb/tb_scalable_digit_glyph_pixel.sv
// Testbench for the scalable digit glyph pixel block: random handshake traffic, scoreboard check.
`timescale 1ns / 100ps

// Predicts each pixel from the current glyph width and holds the pixels still owed
class glyph_pixel_checker;
    logic [scdg_pkg::WID_W-1:0] glyph_width;
    scdg_pkg::t_out_beat        owed_pixels[$];
    int                         errors;

    function new();
        glyph_width = scdg_pkg::WIDTH_RESET;
        errors      = 0;
    endfunction

    function void set_width(logic [scdg_pkg::WID_W-1:0] w);
        glyph_width = w;
    endfunction

    function int pending();
        return owed_pixels.size();
    endfunction

    // Stroke test for one in-glyph pixel
    function bit stroke_hit(scdg_pkg::t_in_beat b, int unsigned w, int unsigned r);
        int unsigned h, s, hi, row, col;
        bit          left, right, ul, ur, ll, lr;
        h     = 2 * w;
        row   = b.pixel_row;
        col   = b.pixel_col;
        left  = col < r;
        right = col >= w - r;
        {ul, ur, ll, lr} = 4'b0000;
        case (b.digit)
            scdg_pkg::DIGIT_ZERO: begin
                if (row < r || row >= h - r) return 1'b1;
                return left || right;
            end
            scdg_pkg::DIGIT_ONE: return right;
            scdg_pkg::DIGIT_SEVEN: begin
                if (row < r) return 1'b1;
                return right;
            end
            scdg_pkg::DIGIT_FOUR: begin
                s  = h - r;
                hi = s - s / 2;
                if (row < hi) return left || right;
                if (row < hi + r) return 1'b1;
                return right;
            end
            scdg_pkg::DIGIT_TWO, scdg_pkg::DIGIT_THREE, scdg_pkg::DIGIT_FIVE,
            scdg_pkg::DIGIT_SIX, scdg_pkg::DIGIT_EIGHT, scdg_pkg::DIGIT_NINE: begin
                // side bars of the upper and lower zones
                case (b.digit)
                    scdg_pkg::DIGIT_TWO:   begin ur = 1'b1; ll = 1'b1; end
                    scdg_pkg::DIGIT_THREE: begin ur = 1'b1; lr = 1'b1; end
                    scdg_pkg::DIGIT_FIVE:  begin ul = 1'b1; lr = 1'b1; end
                    scdg_pkg::DIGIT_SIX:   begin ul = 1'b1; ll = 1'b1; lr = 1'b1; end
                    scdg_pkg::DIGIT_EIGHT: begin ul = 1'b1; ur = 1'b1; ll = 1'b1; lr = 1'b1; end
                    default:               begin ul = 1'b1; ur = 1'b1; lr = 1'b1; end
                endcase
                s  = (h >= 3 * r) ? h - 3 * r : 0;
                hi = s - s / 2;
                if (row < r) return 1'b1;
                if (row < r + hi) return (ul && left) || (ur && right);
                if (row < 2 * r + hi) return 1'b1;
                if (row < h - r) return (ll && left) || (lr && right);
                return 1'b1;
            end
            default: return 1'b0;   // no glyph above nine
        endcase
    endfunction

    function scdg_pkg::t_out_beat glyph_pixel(scdg_pkg::t_in_beat b);
        scdg_pkg::t_out_beat o;
        int unsigned         w, r;
        w = glyph_width;
        if (w > scdg_pkg::MAX_WIDTH) w = scdg_pkg::MAX_WIDTH;
        r = w / scdg_pkg::BASE_DIVISOR;
        o.pixel_on = 1'b0;
        if (r == 0)
            o.status = scdg_pkg::ST_THIN;
        else if (b.pixel_row >= 2 * w || b.pixel_col >= w)
            o.status = scdg_pkg::ST_OUTSIDE;
        else begin
            o.status   = scdg_pkg::ST_OK;
            o.pixel_on = stroke_hit(b, w, r);
        end
        return o;
    endfunction

    function void note_request(scdg_pkg::t_in_beat b);
        owed_pixels.push_back(glyph_pixel(b));
    endfunction

    function void check_pixel(scdg_pkg::t_out_beat got);
        scdg_pkg::t_out_beat exp_px;
        if (owed_pixels.size() == 0) begin
            $display("%0t: unexpected beat: expected none, actual on=%0b status=%0d",
                     $time, got.pixel_on, got.status);
            errors++;
            return;
        end
        exp_px = owed_pixels.pop_front();
        if (got.pixel_on !== exp_px.pixel_on) begin
            $display("%0t: pixel_on mismatch: expected %0b, actual %0b",
                     $time, exp_px.pixel_on, got.pixel_on);
            errors++;
        end
        if (got.status !== exp_px.status) begin
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, exp_px.status, got.status);
            errors++;
        end
    endfunction
endclass

module tb_scalable_digit_glyph_pixel;

    localparam int QUIET_LIMIT = 2000;
    localparam int PHASE_ITEMS = 41;

    logic                       i_clk       = 1'b0;
    logic                       i_rst_n     = 1'b0;
    logic                       i_cfg_we    = 1'b0;
    logic [scdg_pkg::WID_W-1:0] i_cfg_wdata = '0;
    logic                       i_valid     = 1'b0;
    scdg_pkg::t_in_beat         i_beat      = '0;
    logic                       i_stall     = 1'b0;
    logic                       o_stall;
    logic                       o_valid;
    scdg_pkg::t_out_beat        o_beat;

    glyph_pixel_checker pixels = new();

    int stall_pct = 0;
    int gap_pct   = 0;
    int stall_left = 0;
    int quiet_cycles = 0;

    scalable_digit_glyph_pixel u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (i_valid),
        .i_beat      (i_beat),
        .o_stall     (o_stall),
        .o_valid     (o_valid),
        .o_beat      (o_beat),
        .i_stall     (i_stall)
    );

    always #4 i_clk = ~i_clk;

    // Receiver: check accepted beats, stall in random bursts
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            pixels.check_pixel(o_beat);
        if (stall_left > 0) begin
            stall_left--;
            i_stall <= 1'b1;
        end else if (stall_pct > 0 && $urandom_range(1, 100) <= stall_pct) begin
            stall_left = $urandom_range(1, 11) - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= 1'b0;
        end
    end

    // Watchdog on cycles with no beat moving on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL scalable_digit_glyph_pixel");
            $finish;
        end
    end

    // Drive one request and hold it until accepted; valid stays high afterwards
    task automatic send_pixel(scdg_pkg::t_in_beat b);
        i_valid <= 1'b1;
        i_beat  <= b;
        do @(posedge i_clk); while (o_stall);
        pixels.note_request(b);
    endtask

    task automatic hold_off(int cycles);
        i_valid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        while (pixels.pending() > 0) @(posedge i_clk);
    endtask

    // Width change only with the pipeline empty
    task automatic write_width(logic [scdg_pkg::WID_W-1:0] w);
        hold_off(1);
        wait_drained();
        repeat (4) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= w;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        pixels.set_width(w);
    endtask

    function automatic scdg_pkg::t_in_beat pick_pixel(int unsigned w);
        scdg_pkg::t_in_beat b;
        int unsigned        r, h, s4, s5, hi4, hi5, kind;
        int unsigned        rows[14];
        int unsigned        cols[6];
        r    = w / scdg_pkg::BASE_DIVISOR;
        h    = 2 * w;
        s4   = h - r;
        s5   = (h >= 3 * r) ? h - 3 * r : 0;
        hi4  = s4 - s4 / 2;
        hi5  = s5 - s5 / 2;
        rows = '{0, r - 1, r, hi4 - 1, hi4, hi4 + r - 1, hi4 + r, r + hi5 - 1, r + hi5,
                 2 * r + hi5 - 1, 2 * r + hi5, h - r - 1, h - r, h - 1};
        cols = '{0, r - 1, r, w - r - 1, w - r, w - 1};
        kind = $urandom_range(0, 99);
        b.digit = ($urandom_range(0, 99) < 10)
                ? scdg_pkg::DIGIT_W'($urandom_range(10, 15))
                : scdg_pkg::DIGIT_W'($urandom_range(0, 9));
        if (kind < 65) begin
            b.pixel_row = scdg_pkg::ROW_W'($urandom_range(0, h - 1));
            b.pixel_col = scdg_pkg::COL_W'($urandom_range(0, w - 1));
        end else if (kind < 82) begin
            // band and bar edges
            b.pixel_row = scdg_pkg::ROW_W'(rows[$urandom_range(0, 13)] % h);
            b.pixel_col = scdg_pkg::COL_W'(cols[$urandom_range(0, 5)] % w);
        end else if (kind < 92) begin
            if ($urandom_range(0, 1)) begin
                b.pixel_row = scdg_pkg::ROW_W'($urandom_range(h, 511));
                b.pixel_col = scdg_pkg::COL_W'($urandom);
            end else begin
                b.pixel_row = scdg_pkg::ROW_W'($urandom);
                b.pixel_col = scdg_pkg::COL_W'($urandom_range(w, 255));
            end
        end else begin
            b.pixel_row = scdg_pkg::ROW_W'($urandom);
            b.pixel_col = scdg_pkg::COL_W'($urandom);
        end
        return b;
    endfunction

    task automatic run_phase(int unsigned w, int items, bit pause_midway);
        for (int k = 0; k < items; k++) begin
            send_pixel(pick_pixel(w));
            if (pause_midway && k == items / 2) begin
                hold_off(1);
                wait_drained();
            end else if (gap_pct > 0 && $urandom_range(1, 100) <= gap_pct) begin
                hold_off($urandom_range(1, 11));
            end
        end
    endtask

    initial begin
        scdg_pkg::t_in_beat b;
        int unsigned        widths[12];
        widths = '{255, 8, 1, 7, 9, 16, 100, 128, 200, 0, 0, 32};
        widths[9]  = $urandom_range(1, 255);
        widths[10] = $urandom_range(8, 255);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: every digit code at width 32, then the coordinate extremes and a digit-four bar edge
        for (int d = 0; d < 16; d++) begin
            b.digit     = scdg_pkg::DIGIT_W'(d);
            b.pixel_row = scdg_pkg::ROW_W'(2 + d);
            b.pixel_col = scdg_pkg::COL_W'(d * 2);
            send_pixel(b);
        end
        b.digit = scdg_pkg::DIGIT_EIGHT;
        b.pixel_row = '0;      b.pixel_col = '0;      send_pixel(b);
        b.pixel_row = 9'd63;   b.pixel_col = 8'd31;   send_pixel(b);
        b.pixel_row = 9'd64;   b.pixel_col = 8'd0;    send_pixel(b);
        b.pixel_row = 9'd0;    b.pixel_col = 8'd32;   send_pixel(b);
        b.pixel_row = 9'd511;  b.pixel_col = 8'd255;  send_pixel(b);
        b.digit = scdg_pkg::DIGIT_FOUR;
        b.pixel_row = 9'd30;   b.pixel_col = 8'd15;   send_pixel(b);

        // Random at reset width, then across the width settings
        stall_pct = 20;
        gap_pct   = 20;
        run_phase(32, PHASE_ITEMS, 1'b0);
        for (int p = 0; p < 12; p++) begin
            write_width(scdg_pkg::WID_W'(widths[p]));
            if (p == 11) begin
                stall_pct = 0;
                gap_pct   = 0;
            end else begin
                stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
                gap_pct   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
            end
            run_phase(widths[p], PHASE_ITEMS, p == 2);
        end

        hold_off(1);
        wait_drained();
        repeat (10) @(posedge i_clk);
        if (pixels.errors == 0 && pixels.pending() == 0)
            $display("PASS scalable_digit_glyph_pixel");
        else
            $display("FAIL scalable_digit_glyph_pixel");
        $finish;
    end

endmodule
